// File: hw/rtl/srfm_pkg.sv
// Shared types, codes and helpers for the signature rule first-match classifier.
// No dependencies; every other file imports this package.
package srfm_pkg;

  // Default sizes, handed to the top-level parameters
  localparam int unsigned DEF_MAX_RULES       = 64;
  localparam int unsigned DEF_MAX_PATTERN_LEN = 64;
  localparam int unsigned DEF_MAX_QUERY_LEN   = 256;
  localparam int unsigned DEF_MAX_HASH_LEN    = 64;

  localparam logic [7:0] DOT_CHAR = 8'h2e;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_RULE  = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    KIND_SUFFIX   = 3'd0,
    KIND_CONTAINS = 3'd1,
    KIND_EXACT    = 3'd2,
    KIND_JA3      = 3'd3,
    KIND_JA3HASH  = 3'd4,
    KIND_JA4      = 3'd5,
    KIND_JA4PRE   = 3'd6,
    KIND_NONE     = 3'd7
  } kind_t;

  typedef enum logic [1:0] {
    QT_HOST    = 2'd0,
    QT_JA3STR  = 2'd1,
    QT_JA3HASH = 2'd2,
    QT_JA4     = 2'd3
  } qtype_t;

  typedef enum logic [2:0] {
    ST_ADDED   = 3'd0,
    ST_FULL    = 3'd1,
    ST_BADLEN  = 3'd2,
    ST_MATCH   = 3'd3,
    ST_NOMATCH = 3'd4,
    ST_TOOLONG = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HDR_RD,
    S_HDR_CK,
    S_BYTE_RD,
    S_BYTE_CK,
    S_RESULT
  } walk_state_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [2:0] rule_kind;
    logic [7:0] app_id;
    logic [1:0] query_type;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_string;
  } in_t;

  typedef struct packed {
    logic [2:0] status;
    logic       matched;
    logic [7:0] app_out;
    logic [5:0] rule_index;
  } out_t;

  // ASCII lowercase of A-Z only
  function automatic logic [7:0] fold_lc(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5a) r = c + 8'd32;
    return r;
  endfunction

endpackage

// File: hw/rtl/srfm_rule_mem.sv
// Rule table storage: header memory (kind, length, app id) and pattern memory.
// Depends on srfm_pkg.
module srfm_rule_mem
  import srfm_pkg::*;
#(
  parameter int unsigned MAX_RULES       = DEF_MAX_RULES,
  parameter int unsigned MAX_PATTERN_LEN = DEF_MAX_PATTERN_LEN,
  localparam int unsigned RW  = $clog2(MAX_RULES),
  localparam int unsigned LW  = $clog2(MAX_PATTERN_LEN + 1),
  localparam int unsigned HW  = 3 + LW + 8,
  localparam int unsigned PAW = $clog2(MAX_RULES * MAX_PATTERN_LEN)
) (
  input  logic           clk,
  input  logic           hdr_we,
  input  logic [RW-1:0]  hdr_waddr,
  input  logic [HW-1:0]  hdr_wdata,
  input  logic [RW-1:0]  hdr_raddr,
  output logic [HW-1:0]  hdr_rdata,
  input  logic           pat_we,
  input  logic [PAW-1:0] pat_waddr,
  input  logic [7:0]     pat_wdata,
  input  logic [PAW-1:0] pat_raddr,
  output logic [7:0]     pat_rdata
);

  logic [HW-1:0] hdr_mem [MAX_RULES];
  logic [7:0]    pat_mem [MAX_RULES * MAX_PATTERN_LEN];

  // Write header, registered read
  always_ff @(posedge clk) begin
    if (hdr_we) begin
      hdr_mem[hdr_waddr] <= hdr_wdata;
    end
    hdr_rdata <= hdr_mem[hdr_raddr];
  end

  // Write pattern byte, registered read
  always_ff @(posedge clk) begin
    if (pat_we) begin
      pat_mem[pat_waddr] <= pat_wdata;
    end
    pat_rdata <= pat_mem[pat_raddr];
  end

endmodule

// File: hw/rtl/srfm_query_mem.sv
// Query string buffer and JA3 hash buffer, one write and one registered read each.
// Depends on srfm_pkg.
module srfm_query_mem
  import srfm_pkg::*;
#(
  parameter int unsigned MAX_QUERY_LEN = DEF_MAX_QUERY_LEN,
  parameter int unsigned MAX_HASH_LEN  = DEF_MAX_HASH_LEN,
  localparam int unsigned QAW = $clog2(MAX_QUERY_LEN),
  localparam int unsigned HAW = $clog2(MAX_HASH_LEN)
) (
  input  logic           clk,
  input  logic [7:0]     wdata,
  input  logic           q_we,
  input  logic [QAW-1:0] q_waddr,
  input  logic [QAW-1:0] q_raddr,
  output logic [7:0]     q_rdata,
  input  logic           h_we,
  input  logic [HAW-1:0] h_waddr,
  input  logic [HAW-1:0] h_raddr,
  output logic [7:0]     h_rdata
);

  logic [7:0] q_mem [MAX_QUERY_LEN];
  logic [7:0] h_mem [MAX_HASH_LEN];

  // Append query byte, registered read
  always_ff @(posedge clk) begin
    if (q_we) begin
      q_mem[q_waddr] <= wdata;
    end
    q_rdata <= q_mem[q_raddr];
  end

  // Append hash byte, registered read
  always_ff @(posedge clk) begin
    if (h_we) begin
      h_mem[h_waddr] <= wdata;
    end
    h_rdata <= h_mem[h_raddr];
  end

endmodule

// File: hw/rtl/signature_rule_first_match.sv
// Signature rule first-match classifier: request control, rule walk sequencer.
// Depends on srfm_pkg, srfm_rule_mem and srfm_query_mem.
//
// Usage: requests arrive on in_valid/in_stall/in_data, results leave on
// out_valid/out_stall/out_data. A request is taken at an edge with valid high
// and stall low. cmd clear empties the rule table; rule bytes are appended to
// the pattern being loaded and the byte with end_of_string commits the rule,
// unless the table is full or the length is bad, and gives one result in the
// next cycle. Query bytes are buffered one per cycle while in_stall is low;
// the end of a host, JA3 hash or JA4 query gives one result: first match or no
// match from a walk of the rules in table order, or too long without a walk.
// The walk sequencer reads each rule's header, then reads one pattern byte
// and one query byte at a time from the single read ports of the pattern and
// query memories and compares them. No request is taken during a walk. A
// waiting result blocks only requests while out_stall is high. Reset empties
// the rule table and the query buffers; memories are not cleared and need no
// clearing pass. A stalled result holds its value.
module signature_rule_first_match
  import srfm_pkg::*;
#(
  parameter int unsigned MAX_RULES       = DEF_MAX_RULES,
  parameter int unsigned MAX_PATTERN_LEN = DEF_MAX_PATTERN_LEN,
  parameter int unsigned MAX_QUERY_LEN   = DEF_MAX_QUERY_LEN,
  parameter int unsigned MAX_HASH_LEN    = DEF_MAX_HASH_LEN
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  localparam int unsigned RW   = $clog2(MAX_RULES);
  localparam int unsigned CNTW = $clog2(MAX_RULES + 1);
  localparam int unsigned CW   = $clog2(MAX_PATTERN_LEN + 2);
  localparam int unsigned LW   = $clog2(MAX_PATTERN_LEN + 1);
  localparam int unsigned HW   = 3 + LW + 8;
  localparam int unsigned PAW  = $clog2(MAX_RULES * MAX_PATTERN_LEN);
  localparam int unsigned QLW  = $clog2(MAX_QUERY_LEN + 1);
  localparam int unsigned QAW  = $clog2(MAX_QUERY_LEN);
  localparam int unsigned HLW  = $clog2(MAX_HASH_LEN + 1);
  localparam int unsigned HAW  = $clog2(MAX_HASH_LEN);
  localparam int unsigned MW   = ((QLW > LW) ? QLW : LW) + 1;

  walk_state_t state_r, state_nxt;
  logic [CNTW-1:0] rule_count_r, rule_count_nxt;
  logic [CW-1:0]   cursor_r, cursor_nxt;
  logic [QLW-1:0]  qlen_r, qlen_nxt;
  logic [HLW-1:0]  hlen_r, hlen_nxt;
  logic            ovf_r, ovf_nxt;
  logic [CNTW-1:0] rule_r, rule_nxt;
  logic [LW-1:0]   pos_r, pos_nxt;
  logic [QLW-1:0]  off_r, off_nxt;
  logic            dot_r, dot_nxt;
  logic            use_hash_r, use_hash_nxt;
  logic [1:0]      qt_r, qt_nxt;
  logic [QLW-1:0]  h_r, h_nxt;
  logic [HLW-1:0]  hl_r, hl_nxt;
  logic            found_r, found_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_t            out_r, out_nxt;

  logic            accept;
  logic            out_free;
  logic            hdr_we, pat_we, q_we, h_we;
  logic [HW-1:0]   hdr_wdata, hdr_rdata;
  logic [PAW-1:0]  pat_waddr, pat_raddr;
  logic [7:0]      pat_rdata, q_rdata, h_rdata;
  logic [QAW-1:0]  q_raddr;
  logic [HAW-1:0]  h_raddr;
  logic [2:0]      hk;
  logic [LW-1:0]   hn;
  logic [7:0]      happ;
  logic [MW-1:0]   n_w, h_w, hl_w, off_w, pos_w;
  logic [7:0]      qb, pb;
  logic [CW-1:0]   len_c;

  assign {hk, hn, happ} = hdr_rdata;
  assign n_w   = MW'(hn);
  assign h_w   = MW'(h_r);
  assign hl_w  = MW'(hl_r);
  assign off_w = MW'(off_r);
  assign pos_w = MW'(pos_r);

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE) || !out_free;
  assign accept   = in_valid && !in_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Memory addresses for the walk and the loads
  assign pat_waddr = PAW'(rule_count_r[RW-1:0]) * PAW'(MAX_PATTERN_LEN) + PAW'(cursor_r);
  assign pat_raddr = PAW'(rule_r[RW-1:0]) * PAW'(MAX_PATTERN_LEN) + PAW'(pos_r);
  assign q_raddr   = dot_r ? off_r[QAW-1:0] : QAW'(off_w + pos_w);
  assign h_raddr   = HAW'(pos_r);
  assign hdr_wdata = {in_data.rule_kind, LW'(len_c), in_data.app_id};

  // Compare bytes, folded for host queries
  always_comb begin
    qb = use_hash_r ? h_rdata : q_rdata;
    pb = pat_rdata;
    if (qt_r == QT_HOST) begin
      qb = fold_lc(qb);
      pb = fold_lc(pb);
    end
  end

  srfm_rule_mem #(
    .MAX_RULES      (MAX_RULES),
    .MAX_PATTERN_LEN(MAX_PATTERN_LEN)
  ) u_rule_mem (
    .clk      (clk),
    .hdr_we   (hdr_we),
    .hdr_waddr(rule_count_r[RW-1:0]),
    .hdr_wdata(hdr_wdata),
    .hdr_raddr(rule_r[RW-1:0]),
    .hdr_rdata(hdr_rdata),
    .pat_we   (pat_we),
    .pat_waddr(pat_waddr),
    .pat_wdata(in_data.data_byte),
    .pat_raddr(pat_raddr),
    .pat_rdata(pat_rdata)
  );

  srfm_query_mem #(
    .MAX_QUERY_LEN(MAX_QUERY_LEN),
    .MAX_HASH_LEN (MAX_HASH_LEN)
  ) u_query_mem (
    .clk    (clk),
    .wdata  (in_data.data_byte),
    .q_we   (q_we),
    .q_waddr(qlen_r[QAW-1:0]),
    .q_raddr(q_raddr),
    .q_rdata(q_rdata),
    .h_we   (h_we),
    .h_waddr(hlen_r[HAW-1:0]),
    .h_raddr(h_raddr),
    .h_rdata(h_rdata)
  );

  // Hold state and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      rule_count_r <= '0;
      cursor_r     <= '0;
      qlen_r       <= '0;
      hlen_r       <= '0;
      ovf_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      rule_count_r <= rule_count_nxt;
      cursor_r     <= cursor_nxt;
      qlen_r       <= qlen_nxt;
      hlen_r       <= hlen_nxt;
      ovf_r        <= ovf_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Hold walk context and result payload
  always_ff @(posedge clk) begin
    rule_r     <= rule_nxt;
    pos_r      <= pos_nxt;
    off_r      <= off_nxt;
    dot_r      <= dot_nxt;
    use_hash_r <= use_hash_nxt;
    qt_r       <= qt_nxt;
    h_r        <= h_nxt;
    hl_r       <= hl_nxt;
    found_r    <= found_nxt;
    out_r      <= out_nxt;
  end

  // Decode requests and advance the walk
  always_comb begin
    state_nxt      = state_r;
    rule_count_nxt = rule_count_r;
    cursor_nxt     = cursor_r;
    qlen_nxt       = qlen_r;
    hlen_nxt       = hlen_r;
    ovf_nxt        = ovf_r;
    rule_nxt       = rule_r;
    pos_nxt        = pos_r;
    off_nxt        = off_r;
    dot_nxt        = dot_r;
    use_hash_nxt   = use_hash_r;
    qt_nxt         = qt_r;
    h_nxt          = h_r;
    hl_nxt         = hl_r;
    found_nxt      = found_r;
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r && out_stall;
    hdr_we         = 1'b0;
    pat_we         = 1'b0;
    q_we           = 1'b0;
    h_we           = 1'b0;
    len_c          = cursor_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_data.cmd)
            CMD_CLEAR: begin
              rule_count_nxt = '0;
              cursor_nxt     = '0;
            end
            CMD_RULE: begin
              if (in_data.byte_valid) begin
                pat_we = (cursor_r < CW'(MAX_PATTERN_LEN)) &&
                         (rule_count_r < CNTW'(MAX_RULES));
                if (cursor_r <= CW'(MAX_PATTERN_LEN)) cursor_nxt = cursor_r + 1'b1;
              end
              if (in_data.end_of_string) begin
                // Length includes this request's byte
                len_c         = cursor_nxt;
                cursor_nxt    = '0;
                out_valid_nxt = 1'b1;
                out_nxt       = '{status: ST_ADDED, matched: 1'b0, app_out: 8'd0,
                                  rule_index: 6'(rule_count_r)};
                if (rule_count_r >= CNTW'(MAX_RULES)) begin
                  out_nxt.status     = ST_FULL;
                  out_nxt.rule_index = 6'd0;
                end else if (len_c == '0 || len_c > CW'(MAX_PATTERN_LEN)) begin
                  out_nxt.status = ST_BADLEN;
                end else begin
                  hdr_we         = 1'b1;
                  rule_count_nxt = rule_count_r + 1'b1;
                end
              end
            end
            CMD_QUERY: begin
              if (in_data.byte_valid) begin
                if (in_data.query_type == QT_JA3HASH) begin
                  if (hlen_r < HLW'(MAX_HASH_LEN)) begin
                    h_we     = 1'b1;
                    hlen_nxt = hlen_r + 1'b1;
                  end else begin
                    ovf_nxt = 1'b1;
                  end
                end else begin
                  if (qlen_r < QLW'(MAX_QUERY_LEN)) begin
                    q_we     = 1'b1;
                    qlen_nxt = qlen_r + 1'b1;
                  end else begin
                    ovf_nxt = 1'b1;
                  end
                end
              end
              if (in_data.end_of_string && in_data.query_type != QT_JA3STR) begin
                // Overflow seen so far, this request's byte included
                if (ovf_nxt) begin
                  out_valid_nxt = 1'b1;
                  out_nxt       = '{status: ST_TOOLONG, matched: 1'b0, app_out: 8'd0,
                                    rule_index: 6'd0};
                end else begin
                  state_nxt = S_HDR_RD;
                end
                qt_nxt    = in_data.query_type;
                h_nxt     = qlen_nxt;
                hl_nxt    = hlen_nxt;
                qlen_nxt  = '0;
                hlen_nxt  = '0;
                ovf_nxt   = 1'b0;
                rule_nxt  = '0;
                found_nxt = 1'b0;
                dot_nxt   = 1'b0;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_HDR_RD: begin
        if (rule_r >= rule_count_r) begin
          state_nxt = S_RESULT;
        end else begin
          state_nxt = S_HDR_CK;
        end
      end

      // Decide whether this rule can match and where the compare starts
      S_HDR_CK: begin
        pos_nxt      = '0;
        off_nxt      = '0;
        dot_nxt      = 1'b0;
        use_hash_nxt = 1'b0;
        state_nxt    = S_HDR_RD;
        rule_nxt     = rule_r + 1'b1;
        case (qt_r)
          QT_HOST: begin
            if (hk == KIND_SUFFIX) begin
              if (h_w == n_w) begin
                state_nxt = S_BYTE_RD;
              end else if (h_w > n_w) begin
                off_nxt   = QLW'(h_w - n_w - 1'b1);
                dot_nxt   = 1'b1;
                state_nxt = S_BYTE_RD;
              end
            end else if (hk == KIND_CONTAINS) begin
              if (n_w <= h_w) state_nxt = S_BYTE_RD;
            end else if (hk == KIND_EXACT) begin
              if (h_w == n_w) state_nxt = S_BYTE_RD;
            end
          end
          QT_JA3HASH: begin
            if (hk == KIND_JA3 && h_w == n_w) begin
              state_nxt = S_BYTE_RD;
            end else if (hk == KIND_JA3HASH && hl_w == n_w) begin
              use_hash_nxt = 1'b1;
              state_nxt    = S_BYTE_RD;
            end
          end
          QT_JA4: begin
            if ((hk == KIND_JA4 && h_w == n_w) || (hk == KIND_JA4PRE && h_w >= n_w)) begin
              state_nxt = S_BYTE_RD;
            end
          end
          default: begin
          end
        endcase
        if (state_nxt == S_BYTE_RD) rule_nxt = rule_r;
      end

      S_BYTE_RD: begin
        state_nxt = S_BYTE_CK;
      end

      // Compare one byte; advance, slide the window, or drop the rule
      S_BYTE_CK: begin
        state_nxt = S_BYTE_RD;
        if (dot_r) begin
          if (qb == DOT_CHAR) begin
            dot_nxt = 1'b0;
            off_nxt = off_r + 1'b1;
          end else begin
            rule_nxt  = rule_r + 1'b1;
            state_nxt = S_HDR_RD;
          end
        end else if (qb == pb) begin
          if (pos_w == n_w - 1'b1) begin
            found_nxt = 1'b1;
            state_nxt = S_RESULT;
          end else begin
            pos_nxt = pos_r + 1'b1;
          end
        end else if (hk == KIND_CONTAINS && qt_r == QT_HOST && off_w + n_w < h_w) begin
          off_nxt = off_r + 1'b1;
          pos_nxt = '0;
        end else begin
          rule_nxt  = rule_r + 1'b1;
          state_nxt = S_HDR_RD;
        end
      end

      S_RESULT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '{status: ST_NOMATCH, matched: 1'b0, app_out: 8'd0,
                            rule_index: 6'd0};
          if (found_r) begin
            out_nxt = '{status: ST_MATCH, matched: 1'b1, app_out: happ,
                        rule_index: 6'(rule_r)};
          end
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

`ifndef SYNTH
  a_walk_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> in_stall)
    else $error("request taken during rule walk");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    rule_count_r <= CNTW'(MAX_RULES))
    else $error("rule count beyond table size");

  a_match_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.matched) |-> (out_r.status == ST_MATCH))
    else $error("matched flag without match status");

  a_walk_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_HDR_CK || state_r == S_BYTE_RD || state_r == S_BYTE_CK)
      |-> (rule_r < rule_count_r))
    else $error("walk beyond committed rules");

  a_result_leaves: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESULT && out_free) |=> (out_valid_r && state_r == S_IDLE))
    else $error("walk result not delivered");
`endif

endmodule
